// File: src/iq_to_magnitude_phase_macros.svh
// assertion macros shared by the magnitude and phase converter
`ifndef IQ_TO_MAGNITUDE_PHASE_MACROS_SVH
`define IQ_TO_MAGNITUDE_PHASE_MACROS_SVH

// same-cycle implication
`define IQMP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define IQMP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/iqmp_pkg.sv
// types, widths and the arctangent table of the magnitude and phase converter
package iqmp_pkg;

   localparam int SAMPLE_BITS  = 8;
   localparam int SQ_BITS      = 2 * SAMPLE_BITS;
   localparam int REM_BITS     = SAMPLE_BITS + 3;
   localparam int CORDIC_ITERS = 2 * SAMPLE_BITS + 26;
   // angle is kept in centidegrees with ANG_FRAC fraction bits
   localparam int ANG_FRAC     = 2 * SAMPLE_BITS + 16;
   localparam int ANG_BITS     = ANG_FRAC + 16;
   localparam int GUARD_FRAC   = 2 * SAMPLE_BITS + 31;
   localparam int XY_BITS      = SAMPLE_BITS + 2 + GUARD_FRAC;
   localparam int MAG_BITS     = 8;
   localparam int PHASE_BITS   = 16;
   localparam int MAG_MAX      = 255;
   localparam int PHASE_LIM    = 18000;

   localparam real CENTIDEG_PER_RAD = 18000.0 / 3.14159265358979323846;

   localparam logic [ANG_BITS-1:0] QUARTER_FX    = ANG_BITS'(9000) << ANG_FRAC;
   localparam logic [ANG_BITS-1:0] HALF_FX       = ANG_BITS'(1) << (ANG_FRAC - 1);
   localparam logic [ANG_BITS-1:0] TURN_ROUND_FX =
      (ANG_BITS'(PHASE_LIM) << ANG_FRAC) + HALF_FX;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] local_i;
      logic signed [SAMPLE_BITS-1:0] local_q;
      logic signed [SAMPLE_BITS-1:0] remote_i;
      logic signed [SAMPLE_BITS-1:0] remote_q;
      logic                          fuse;
   } iqmp_req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] used_i;
      logic signed [SAMPLE_BITS-1:0] used_q;
      logic        [MAG_BITS-1:0]    magnitude;
      logic signed [PHASE_BITS-1:0]  phase_centideg;
   } iqmp_rsp_type;

   // what one cell of the row hands to the next
   typedef struct packed {
      logic signed [XY_BITS-1:0]     x;
      logic signed [XY_BITS-1:0]     y;
      logic signed [ANG_BITS-1:0]    z;
      logic        [SQ_BITS-1:0]     sq_n;
      logic        [REM_BITS-1:0]    sq_rem;
      logic        [SAMPLE_BITS-1:0] sq_root;
      logic signed [SAMPLE_BITS-1:0] used_i;
      logic signed [SAMPLE_BITS-1:0] used_q;
      logic                          neg_i;
      logic                          neg_q;
      logic                          im_zero;
      logic                          re_zero;
   } iqmp_cell_type;

   // atan(2^-idx) in centidegrees, scaled by 2^ANG_FRAC
   function automatic logic signed [ANG_BITS-1:0] atan_entry(input int idx);
      real ang;
      ang = $atan(2.0 ** (-idx)) * CENTIDEG_PER_RAD * (2.0 ** ANG_FRAC);
      return ANG_BITS'(longint'(ang));
   endfunction

endpackage

// File: src/iqmp_prep.sv
// input stage: optional averaging, folding to the first quadrant, squares
module iqmp_prep (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  logic                    up_valid,
   input  iqmp_pkg::iqmp_req_type  up_data,
   output logic                    dn_valid,
   output iqmp_pkg::iqmp_cell_type dn_data
);
   import iqmp_pkg::*;

   logic signed [SAMPLE_BITS:0]   sum_i, sum_q, adj_i, adj_q;
   logic signed [SAMPLE_BITS-1:0] vi, vq;
   logic        [SAMPLE_BITS-1:0] ai, aq;
   logic        [SQ_BITS-1:0]     ai_sq, aq_sq;
   iqmp_cell_type                 cell_in, cell_ff;
   logic                          valid_ff;

   always_comb begin
      sum_i = {up_data.local_i[SAMPLE_BITS-1], up_data.local_i}
            + {up_data.remote_i[SAMPLE_BITS-1], up_data.remote_i};
      sum_q = {up_data.local_q[SAMPLE_BITS-1], up_data.local_q}
            + {up_data.remote_q[SAMPLE_BITS-1], up_data.remote_q};
      // bias negative sums by one so the halving truncates toward zero
      adj_i = sum_i + (SAMPLE_BITS + 1)'(sum_i[SAMPLE_BITS]);
      adj_q = sum_q + (SAMPLE_BITS + 1)'(sum_q[SAMPLE_BITS]);
      if (up_data.fuse) begin
         vi = adj_i[SAMPLE_BITS:1];
         vq = adj_q[SAMPLE_BITS:1];
      end else begin
         vi = up_data.local_i;
         vq = up_data.local_q;
      end
      ai = vi[SAMPLE_BITS-1] ? SAMPLE_BITS'(~vi + 1'b1) : SAMPLE_BITS'(vi);
      aq = vq[SAMPLE_BITS-1] ? SAMPLE_BITS'(~vq + 1'b1) : SAMPLE_BITS'(vq);
      ai_sq = {SAMPLE_BITS'(0), ai} * {SAMPLE_BITS'(0), ai};
      aq_sq = {SAMPLE_BITS'(0), aq} * {SAMPLE_BITS'(0), aq};

      cell_in.x       = {2'b00, aq, GUARD_FRAC'(0)};
      cell_in.y       = {2'b00, ai, GUARD_FRAC'(0)};
      cell_in.z       = '0;
      cell_in.sq_n    = ai_sq + aq_sq;
      cell_in.sq_rem  = '0;
      cell_in.sq_root = '0;
      cell_in.used_i  = vi;
      cell_in.used_q  = vq;
      cell_in.neg_i   = vi[SAMPLE_BITS-1];
      cell_in.neg_q   = vq[SAMPLE_BITS-1];
      cell_in.im_zero = (ai == '0);
      cell_in.re_zero = (aq == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cell_ff <= cell_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = cell_ff;

endmodule

// File: src/iqmp_cell.sv
// one cell of the row: a vectoring rotation and, in the first cells, one root digit
module iqmp_cell #(
   parameter int STAGE = 0
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  logic                    up_valid,
   input  iqmp_pkg::iqmp_cell_type up_data,
   output logic                    dn_valid,
   output iqmp_pkg::iqmp_cell_type dn_data
);
   import iqmp_pkg::*;

   localparam logic signed [ANG_BITS-1:0] ATAN_STEP = atan_entry(STAGE);

   logic signed [XY_BITS-1:0] x_sh, y_sh;
   logic        [REM_BITS-1:0] rem_sh, trial;
   iqmp_cell_type             cell_in, cell_ff;
   logic                      valid_ff;

   always_comb begin
      cell_in = up_data;
      x_sh    = up_data.x >>> STAGE;
      y_sh    = up_data.y >>> STAGE;
      // rotate toward the real axis
      if (!up_data.y[XY_BITS-1]) begin
         cell_in.x = up_data.x + y_sh;
         cell_in.y = up_data.y - x_sh;
         cell_in.z = up_data.z + ATAN_STEP;
      end else begin
         cell_in.x = up_data.x - y_sh;
         cell_in.y = up_data.y + x_sh;
         cell_in.z = up_data.z - ATAN_STEP;
      end

      // restoring square root, two radicand bits per cell
      rem_sh = {up_data.sq_rem[REM_BITS-3:0], up_data.sq_n[SQ_BITS-1 -: 2]};
      trial  = {1'b0, up_data.sq_root, 2'b01};
      if (STAGE < SAMPLE_BITS) begin
         cell_in.sq_n = {up_data.sq_n[SQ_BITS-3:0], 2'b00};
         if (rem_sh >= trial) begin
            cell_in.sq_rem  = rem_sh - trial;
            cell_in.sq_root = {up_data.sq_root[SAMPLE_BITS-2:0], 1'b1};
         end else begin
            cell_in.sq_rem  = rem_sh;
            cell_in.sq_root = {up_data.sq_root[SAMPLE_BITS-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cell_ff <= cell_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = cell_ff;

endmodule

// File: src/iqmp_post.sv
// output stage: root rounding, quadrant unfolding and centidegree rounding
module iqmp_post (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  logic                    up_valid,
   input  iqmp_pkg::iqmp_cell_type up_data,
   output logic                    dn_valid,
   output iqmp_pkg::iqmp_rsp_type  dn_data
);
   import iqmp_pkg::*;

   logic [SAMPLE_BITS:0]    mag_round;
   logic [ANG_BITS-1:0]     zc, rnd;
   logic [PHASE_BITS-1:0]   cd;
   iqmp_rsp_type            rsp_in, rsp_ff;
   logic                    valid_ff;

   always_comb begin
      // round up when the remainder passes the root
      mag_round = {1'b0, up_data.sq_root}
                + (SAMPLE_BITS + 1)'(up_data.sq_rem > REM_BITS'(up_data.sq_root));

      if (up_data.im_zero) begin
         zc = '0;
      end else if (up_data.re_zero) begin
         zc = QUARTER_FX;
      end else if (up_data.z[ANG_BITS-1]) begin
         zc = '0;
      end else if (ANG_BITS'(up_data.z) > QUARTER_FX) begin
         zc = QUARTER_FX;
      end else begin
         zc = ANG_BITS'(up_data.z);
      end

      // left half plane mirrors the angle about the imaginary axis
      rnd = up_data.neg_q ? (TURN_ROUND_FX - zc) : (zc + HALF_FX);
      cd  = rnd[ANG_BITS-1:ANG_FRAC];
      if (cd > PHASE_BITS'(PHASE_LIM)) begin
         cd = PHASE_BITS'(PHASE_LIM);
      end

      rsp_in.used_i    = up_data.used_i;
      rsp_in.used_q    = up_data.used_q;
      rsp_in.magnitude = (mag_round > (SAMPLE_BITS + 1)'(MAG_MAX))
                       ? MAG_BITS'(MAG_MAX) : MAG_BITS'(mag_round);
      rsp_in.phase_centideg = up_data.neg_i ? PHASE_BITS'(~cd + 1'b1) : cd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = rsp_ff;

endmodule

// File: src/iq_to_magnitude_phase.sv
// Register stages: the input stage, 42 CORDIC cells and the output stage; the first 8
// cells also take one root digit each.
// Throughput: one transaction per cycle while rsp_ready is high or some stage is empty;
// every stage of the cell row holds its own transaction and a stalled output only holds
// stages up to the nearest bubble.
// Reset: synchronous, active high; clears the stage valid bits, payload is not reset.
`include "iq_to_magnitude_phase_macros.svh"

module iq_to_magnitude_phase (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  iqmp_pkg::iqmp_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output iqmp_pkg::iqmp_rsp_type rsp_data
);
   import iqmp_pkg::*;

   localparam int STAGES = CORDIC_ITERS + 2;

   logic [STAGES-1:0] vld_w;
   logic [STAGES-1:0] adv_w;
   iqmp_cell_type     chain_w [0:CORDIC_ITERS];

   // a stage loads when it or any stage after it is empty, or the output drains
   always_comb begin
      for (int s = 0; s < STAGES; s++) begin
         adv_w[s] = rsp_ready | (|(~vld_w & ({STAGES{1'b1}} << s)));
      end
   end

   iqmp_prep u_prep (
      .clock    (clock),
      .reset    (reset),
      .load     (adv_w[0]),
      .up_valid (req_valid),
      .up_data  (req_data),
      .dn_valid (vld_w[0]),
      .dn_data  (chain_w[0])
   );

   for (genvar k = 0; k < CORDIC_ITERS; k++) begin : g_cell
      iqmp_cell #(
         .STAGE (k)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .load     (adv_w[k+1]),
         .up_valid (vld_w[k]),
         .up_data  (chain_w[k]),
         .dn_valid (vld_w[k+1]),
         .dn_data  (chain_w[k+1])
      );
   end

   iqmp_post u_post (
      .clock    (clock),
      .reset    (reset),
      .load     (adv_w[STAGES-1]),
      .up_valid (vld_w[STAGES-2]),
      .up_data  (chain_w[CORDIC_ITERS]),
      .dn_valid (vld_w[STAGES-1]),
      .dn_data  (rsp_data)
   );

   assign req_ready = adv_w[0];
   assign rsp_valid = vld_w[STAGES-1];

   `IQMP_ASSERT_NOW(a_ready_when_out_empty, clock, reset, !rsp_valid, req_ready,
      "input held off with an empty output stage")
   `IQMP_ASSERT_NEXT(a_accept_enters_row, clock, reset, req_valid && req_ready, vld_w[0],
      "accepted transaction missing from the input stage")
   `IQMP_ASSERT_NOW(a_phase_in_range, clock, reset, rsp_valid,
      (rsp_data.phase_centideg >= -PHASE_LIM) && (rsp_data.phase_centideg <= PHASE_LIM),
      "phase outside half turn")
   `IQMP_ASSERT_NOW(a_zero_vector, clock, reset,
      rsp_valid && (rsp_data.used_i == '0) && (rsp_data.used_q == '0),
      (rsp_data.magnitude == '0) && (rsp_data.phase_centideg == '0),
      "zero vector gives nonzero result")

endmodule

// File: dv/tb_iq_to_magnitude_phase.sv
// testbench for iq_to_magnitude_phase: directed and random samples with handshake stalls
module tb_iq_to_magnitude_phase;
   import iqmp_pkg::*;

   localparam real PI_VAL          = 3.14159265358979323846;
   localparam int  RANDOM_SAMPLES  = 1330;
   localparam int  MAX_REPORTS     = 10;
   localparam int  QUIET_FIRST     = 700;
   localparam int  QUIET_LAST      = 1000;
   localparam int  HOLD_AFTER      = 250;
   localparam int  HOLD_CYCLES     = 150;
   localparam int  DRAIN_LIMIT     = 20000;
   localparam int  TAIL_CYCLES     = 60;
   localparam int  WATCHDOG_CYCLES = 300000;

   // expected polar results for accepted samples, oldest first
   class polar_scoreboard;
      iqmp_rsp_type expected_polar[$];
      int           error_count = 0;

      function iqmp_rsp_type to_polar(iqmp_req_type s);
         int           im_v;
         int           re_v;
         int           sq_sum;
         int           root;
         int           cd;
         real          ang;
         iqmp_rsp_type r;
         im_v = $signed(s.local_i);
         re_v = $signed(s.local_q);
         if (s.fuse) begin
            // integer division truncates toward zero
            im_v = (im_v + $signed(s.remote_i)) / 2;
            re_v = (re_v + $signed(s.remote_q)) / 2;
         end
         sq_sum = im_v * im_v + re_v * re_v;
         root = 0;
         while ((root + 1) * (root + 1) <= sq_sum) root++;
         // n above r*r+r means sqrt(n) is past r+0.5
         if (sq_sum > root * root + root) root++;
         if (root > MAG_MAX) root = MAG_MAX;
         if (im_v == 0 && re_v == 0) begin
            cd = 0;
         end else begin
            // angle of |I| against Q lies in [0, pi], so the negative real axis gives +18000
            ang = $atan2(real'(im_v < 0 ? -im_v : im_v), real'(re_v));
            cd  = int'(ang * 18000.0 / PI_VAL);
            if (cd > PHASE_LIM) cd = PHASE_LIM;
            if (im_v < 0) cd = -cd;
         end
         r.used_i         = SAMPLE_BITS'(im_v);
         r.used_q         = SAMPLE_BITS'(re_v);
         r.magnitude      = MAG_BITS'(root);
         r.phase_centideg = PHASE_BITS'(cd);
         return r;
      endfunction

      function void report(string what, iqmp_rsp_type want, iqmp_rsp_type got);
         error_count++;
         if (error_count <= MAX_REPORTS)
            $display("%s: expected i=%0d q=%0d mag=%0d ph=%0d, got i=%0d q=%0d mag=%0d ph=%0d",
                     what, want.used_i, want.used_q, want.magnitude, want.phase_centideg,
                     got.used_i, got.used_q, got.magnitude, got.phase_centideg);
      endfunction

      function void note_sample(iqmp_req_type s);
         expected_polar.push_back(to_polar(s));
      endfunction

      function void check_result(iqmp_rsp_type got);
         iqmp_rsp_type want;
         if (expected_polar.size() == 0) begin
            report("unexpected transaction", '0, got);
            return;
         end
         want = expected_polar.pop_front();
         if (got.used_i !== want.used_i || got.used_q !== want.used_q ||
             got.magnitude !== want.magnitude || got.phase_centideg !== want.phase_centideg)
            report("mismatch", want, got);
      endfunction

      function int pending();
         return expected_polar.size();
      endfunction

      function void flush_leftover();
         while (expected_polar.size() != 0)
            report("missing transaction", expected_polar.pop_front(), '0);
      endfunction
   endclass

   logic         clock;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   iqmp_req_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   iqmp_rsp_type rsp_data;

   polar_scoreboard polar_sb = new();
   int              samples_sent = 0;
   bit              held_once = 1'b0;

   iq_to_magnitude_phase u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #(20 * WATCHDOG_CYCLES);
      $display("DONE: errors detected");
      $finish;
   end

   function automatic bit quiet_window();
      return samples_sent >= QUIET_FIRST && samples_sent < QUIET_LAST;
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] extreme_value();
      case ($urandom_range(0, 5))
         0: return -128;
         1: return -127;
         2: return -1;
         3: return 0;
         4: return 1;
         default: return 127;
      endcase
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] small_value();
      return SAMPLE_BITS'(int'($urandom_range(0, 8)) - 4);
   endfunction

   function automatic iqmp_req_type random_sample();
      iqmp_req_type s;
      int           kind;
      s.local_i  = SAMPLE_BITS'($urandom);
      s.local_q  = SAMPLE_BITS'($urandom);
      s.remote_i = SAMPLE_BITS'($urandom);
      s.remote_q = SAMPLE_BITS'($urandom);
      s.fuse     = 1'($urandom_range(0, 1));
      kind = $urandom_range(0, 99);
      if (kind < 15) begin
         // near the origin the angles are coarse and axes are hit often
         s.local_i  = small_value();
         s.local_q  = small_value();
         s.remote_i = small_value();
         s.remote_q = small_value();
      end else if (kind < 27) begin
         if ($urandom_range(0, 1)) s.local_i = '0;
         else s.local_q = '0;
         s.fuse = 1'b0;
      end else if (kind < 35) begin
         s.local_i  = extreme_value();
         s.local_q  = extreme_value();
         s.remote_i = extreme_value();
         s.remote_q = extreme_value();
      end
      return s;
   endfunction

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_sample(input iqmp_req_type s);
      int gap;
      // outside the quiet window, 2 samples in 100 are preceded by an idle gap
      if (!quiet_window() && $urandom_range(0, 99) < 2) begin
         gap = $urandom_range(1, 5);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= s;
      do @(posedge clock); while (!req_ready);
      polar_sb.note_sample(s);
      samples_sent++;
      @(negedge clock);
   endtask

   task automatic send_fields(input int li, input int lq, input int ri, input int rq,
                              input bit fz);
      iqmp_req_type s;
      s.local_i  = SAMPLE_BITS'(li);
      s.local_q  = SAMPLE_BITS'(lq);
      s.remote_i = SAMPLE_BITS'(ri);
      s.remote_q = SAMPLE_BITS'(rq);
      s.fuse     = fz;
      send_sample(s);
   endtask

   // receiver: random stalls, one long hold-off that backs up the pipeline
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else if (!held_once && samples_sent >= HOLD_AFTER) begin
            held_once = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            rsp_ready <= 1'b0;
         end else if (quiet_window()) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= 6);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         polar_sb.check_result(rsp_data);
   end

   initial begin
      int drain;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_fields(0, 0, 0, 0, 0);             // zero vector
      send_fields(0, -1, 0, 0, 0);            // negative real axis
      send_fields(0, -128, 0, 0, 0);
      send_fields(0, 1, 0, 0, 0);
      send_fields(0, 127, 0, 0, 0);
      send_fields(1, 0, 0, 0, 0);             // imaginary axis
      send_fields(-1, 0, 0, 0, 0);
      send_fields(127, 0, 0, 0, 0);
      send_fields(-128, 0, 0, 0, 0);
      send_fields(127, 127, 0, 0, 0);
      send_fields(-128, -128, 0, 0, 0);
      send_fields(127, -128, 0, 0, 0);
      send_fields(-128, 127, 0, 0, 0);
      send_fields(1, -128, 0, 0, 0);          // just off the branch cut
      send_fields(-1, -128, 0, 0, 0);
      send_fields(-1, -1, 0, 0, 0);
      send_fields(5, 3, -128, 127, 0);        // remote ignored without fuse
      send_fields(-128, -128, -128, -128, 1);
      send_fields(127, 127, 127, 127, 1);
      send_fields(-3, 3, 0, 0, 1);            // odd sums truncate toward zero
      send_fields(127, -128, -128, 127, 1);   // fused to the zero vector
      send_fields(1, -2, 0, -3, 1);           // fused onto the negative real axis
      send_fields(-128, 127, 127, -128, 1);

      for (int n = 0; n < RANDOM_SAMPLES; n++)
         send_sample(random_sample());
      req_valid <= 1'b0;

      drain = 0;
      while (polar_sb.pending() != 0 && drain < DRAIN_LIMIT) begin
         @(posedge clock);
         drain++;
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      polar_sb.flush_leftover();
      if (polar_sb.error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// File: sim.f
+incdir+src
src/iqmp_pkg.sv
src/iqmp_prep.sv
src/iqmp_cell.sv
src/iqmp_post.sv
src/iq_to_magnitude_phase.sv
dv/tb_iq_to_magnitude_phase.sv
